// File: sv/sorted_key_set_core_macros.svh
// ----------------------------------------------------------------------------
// sorted key set assertion macros
// shared concurrent assertion helpers for the sorted key set block
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_SET_CORE_MACROS_SVH
`define SORTED_KEY_SET_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SKSET_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key set assertion failed");

// next-cycle implication
`define SKSET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key set assertion failed");

`else

`define SKSET_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SKSET_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/skset_pkg.sv
// ----------------------------------------------------------------------------
// skset_pkg
// types and codes shared by the sorted key set cells and top level
// ----------------------------------------------------------------------------
`default_nettype none

package skset_pkg;

    localparam int KeyWidth = 31;
    localparam int OpWidth  = 2;
    localparam int PosWidth = 7;
    localparam int StWidth  = 2;

    localparam logic [OpWidth-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OpWidth-1:0] OP_INSERT = 2'd1;
    localparam logic [OpWidth-1:0] OP_DELETE = 2'd2;

    localparam logic [StWidth-1:0] STATUS_OK     = 2'd0;
    localparam logic [StWidth-1:0] STATUS_FULL   = 2'd1;
    localparam logic [StWidth-1:0] STATUS_ABSENT = 2'd2;

    typedef struct packed {
        logic [OpWidth-1:0]  op;
        logic [KeyWidth-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [PosWidth-1:0] position;
        logic [PosWidth-1:0] count;
        logic [StWidth-1:0]  status;
    } out_item_t;

    // per-cycle commands to every cell
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

endpackage

`default_nettype wire

// File: sv/skset_cell.sv
// ----------------------------------------------------------------------------
// skset_cell
// one slot of the sorted store: holds a key, compares it against the request
// and shifts with its neighbors on insert or delete
// ----------------------------------------------------------------------------
`default_nettype none

module skset_cell #(
    parameter int IDX   = 0,
    parameter int DEPTH = 64
) (
    input  logic                                aclk,
    input  skset_pkg::cell_ctrl_t               ctrl,
    input  logic [skset_pkg::KeyWidth-1:0]      req_key,
    input  logic [$clog2(DEPTH+1)-1:0]          count,
    input  logic [skset_pkg::KeyWidth-1:0]      left_key,
    input  logic                                left_lt,
    input  logic [skset_pkg::KeyWidth-1:0]      right_key,
    output logic [skset_pkg::KeyWidth-1:0]      key,
    output logic                                lt,
    output logic                                eq
);
    import skset_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [KeyWidth-1:0] key_reg;
    logic [KeyWidth-1:0] key_next;
    logic                lt_reg;
    logic                eq_reg;
    logic                in_use;

    assign in_use = CNT_W'(IDX) < count;

    always_comb begin
        key_next = key_reg;
        if (ctrl.ins && !lt_reg) begin
            // the first cell at or past the insert point takes the new key
            key_next = left_lt ? req_key : left_key;
        end else if (ctrl.del && !lt_reg) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (ctrl.cmp) begin
            lt_reg <= in_use && (key_reg < req_key);
            eq_reg <= in_use && (key_reg == req_key);
        end
    end

    assign key = key_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

`default_nettype wire

// File: sv/skset_pos_enc.sv
// ----------------------------------------------------------------------------
// skset_pos_enc
// turns the thermometer of less-than flags into the insert position and
// collapses the equal flags into a hit
// ----------------------------------------------------------------------------
`default_nettype none

module skset_pos_enc #(
    parameter int DEPTH = 64
) (
    input  logic [DEPTH-1:0]             lt_vec,
    input  logic [DEPTH-1:0]             eq_vec,
    output logic [$clog2(DEPTH+1)-1:0]   position,
    output logic                         found,
    output logic [DEPTH-1:0]             edge_vec
);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // last cell of the run of smaller keys
    always_comb begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            edge_vec[i] = lt_vec[i] && !lt_vec[i+1];
        end
        edge_vec[DEPTH-1] = lt_vec[DEPTH-1];
    end

    always_comb begin
        position = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (edge_vec[i]) begin
                position = position | CNT_W'(i + 1);
            end
        end
    end

    assign found = |eq_vec;

endmodule

`default_nettype wire

// File: sv/sorted_key_set_core.sv
// ----------------------------------------------------------------------------
// sorted_key_set_core
// ordered set of 31-bit keys with lookup, insert and delete
// ----------------------------------------------------------------------------
// Each item passes a compare state and an update state: in the compare state
// every cell compares its key with the request at once, in the update state
// the position is encoded from those flags, the cells shift up or down by one
// for an insert or a delete, and the result is loaded into the output register.
// The next item is accepted in the update state while the result is taken; a
// result that is not taken holds the block there. The store needs no clearing
// after reset: only cells below the count are ever compared.
`default_nettype none

module sorted_key_set_core #(
    parameter int DEPTH = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  skset_pkg::in_item_t    s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output skset_pkg::out_item_t   m_item
);
    import skset_pkg::*;

`include "sorted_key_set_core_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t             state_reg;
    state_t             state_next;
    in_item_t           req_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    out_item_t          m_item_reg;
    out_item_t          m_item_next;

    logic               out_free;
    logic               commit;
    cell_ctrl_t         ctrl;

    logic [KeyWidth-1:0] cell_key [DEPTH];
    logic [DEPTH-1:0]    lt_vec;
    logic [DEPTH-1:0]    eq_vec;
    logic [DEPTH-1:0]    edge_vec;
    logic [CNT_W-1:0]    position;
    logic                found;
    logic                do_ins;
    logic                do_del;
    logic [StWidth-1:0]  status;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [KeyWidth-1:0] left_key;
        logic                left_lt;
        logic [KeyWidth-1:0] right_key;

        if (i == 0) begin : g_first
            assign left_key = req_reg.key;
            assign left_lt  = 1'b1;
        end else begin : g_mid
            assign left_key = cell_key[i-1];
            assign left_lt  = lt_vec[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_key = cell_key[i];
        end else begin : g_inner
            assign right_key = cell_key[i+1];
        end

        skset_cell #(
            .IDX   (i),
            .DEPTH (DEPTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .req_key   (req_reg.key),
            .count     (count_reg),
            .left_key  (left_key),
            .left_lt   (left_lt),
            .right_key (right_key),
            .key       (cell_key[i]),
            .lt        (lt_vec[i]),
            .eq        (eq_vec[i])
        );
    end

    skset_pos_enc #(
        .DEPTH (DEPTH)
    ) u_pos_enc (
        .lt_vec   (lt_vec),
        .eq_vec   (eq_vec),
        .position (position),
        .found    (found),
        .edge_vec (edge_vec)
    );

    assign out_free = !m_valid_reg || m_ready;

    // operation decode, valid in the update cycle
    always_comb begin
        do_ins = 1'b0;
        do_del = 1'b0;
        status = STATUS_OK;
        case (req_reg.op)
            OP_INSERT: begin
                if (!found) begin
                    if (count_reg == CNT_W'(DEPTH)) begin
                        status = STATUS_FULL;
                    end else begin
                        do_ins = 1'b1;
                    end
                end
            end
            OP_DELETE: begin
                if (found) begin
                    do_del = 1'b1;
                end else begin
                    status = STATUS_ABSENT;
                end
            end
            default: begin
                // lookup and the unused code leave the store alone
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) begin
                    state_next = s_valid ? ST_CMP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        commit   = 1'b0;
        ctrl.cmp = 1'b0;
        ctrl.ins = 1'b0;
        ctrl.del = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_CMP: begin
                ctrl.cmp = 1'b1;
            end
            ST_UPD: begin
                s_ready  = out_free;
                commit   = out_free;
                ctrl.ins = out_free && do_ins;
                ctrl.del = out_free && do_del;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (commit) begin
            m_valid_next         = 1'b1;
            m_item_next.found    = found;
            m_item_next.position = PosWidth'(position);
            m_item_next.count    = PosWidth'(count_next);
            m_item_next.status   = status;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
        if (s_valid && s_ready) begin
            req_reg <= s_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `SKSET_ASSERT_NOW(a_count_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SKSET_ASSERT_NOW(a_single_edge, aclk, aresetn, state_reg == ST_UPD, $onehot0(edge_vec))
    `SKSET_ASSERT_NEXT(a_commit_shows, aclk, aresetn, commit, m_valid_reg)
    `SKSET_ASSERT_NEXT(a_count_step, aclk, aresetn, 1'b1, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_W'(1)) || (count_reg == $past(count_reg) - CNT_W'(1)))
    `SKSET_ASSERT_NOW(a_no_shift_both, aclk, aresetn, ctrl.ins || ctrl.del, commit && !(ctrl.ins && ctrl.del))

endmodule

`default_nettype wire

// File: sim/tb_sorted_key_set_core.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_set_core
// self-checking bench for the sorted key set: lookups, inserts and deletes
// are mirrored in a small array model whose expected results are matched in
// order against every result the block hands back
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_key_set_core;
    import skset_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [OpWidth-1:0] OP_UNUSED = 2'd3;
    localparam logic [KeyWidth-1:0] KEY_MAX = {KeyWidth{1'b1}};

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_item;

    sorted_key_set_core #(.DEPTH(DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // mirror of the key store
    logic [KeyWidth-1:0] set_keys [DEPTH];
    int unsigned set_count = 0;

    out_item_t pending_results [$];
    out_item_t oldest_pending;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int full_drops = 0;
    int absent_deletes = 0;
    int cycle_count = 0;

    function automatic out_item_t apply_to_set(in_item_t it);
        out_item_t res;
        int unsigned smaller;
        bit hit;
        smaller = 0;
        for (int i = 0; i < set_count; i++) begin
            if (set_keys[i] < it.key) smaller++;
        end
        hit = (smaller < set_count) && (set_keys[smaller] == it.key);
        res.found = hit;
        res.position = smaller[PosWidth-1:0];
        res.status = STATUS_OK;
        if (it.op == OP_INSERT && !hit) begin
            if (set_count >= DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                for (int i = set_count; i > smaller; i--) set_keys[i] = set_keys[i-1];
                set_keys[smaller] = it.key;
                set_count++;
            end
        end else if (it.op == OP_DELETE) begin
            if (!hit) begin
                res.status = STATUS_ABSENT;
            end else begin
                for (int i = smaller; i + 1 < set_count; i++) set_keys[i] = set_keys[i+1];
                set_count--;
            end
        end
        res.count = set_count[PosWidth-1:0];
        return res;
    endfunction

    // present key, a neighbor of one, an extreme, or anything
    function automatic logic [KeyWidth-1:0] choose_key(int present_pct);
        logic [KeyWidth-1:0] k;
        int sel;
        sel = $urandom_range(0, 99);
        k = KeyWidth'($urandom());
        if (set_count > 0 && sel < present_pct) begin
            k = set_keys[$urandom_range(0, set_count - 1)];
        end else if (set_count > 0 && sel < present_pct + 20) begin
            k = set_keys[$urandom_range(0, set_count - 1)];
            k = ($urandom_range(0, 1) != 0) ? k + 1'b1 : k - 1'b1;
        end else if (sel >= 95) begin
            k = ($urandom_range(0, 1) != 0) ? KEY_MAX : '0;
        end
        return k;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (result %0d, cycle %0d)",
                 what, got, want, results_checked, cycle_count);
        errors++;
    endtask

    task automatic send_item(input logic [OpWidth-1:0] op, input logic [KeyWidth-1:0] key);
        in_item_t it;
        it.op = op;
        it.key = key;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_to_set(it));
        items_sent++;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end else begin
                oldest_pending = pending_results.pop_front();
                if (m_item.found !== oldest_pending.found)
                    report_mismatch("found", int'(m_item.found),
                                    int'(oldest_pending.found));
                if (m_item.position !== oldest_pending.position)
                    report_mismatch("position", int'(m_item.position),
                                    int'(oldest_pending.position));
                if (m_item.count !== oldest_pending.count)
                    report_mismatch("count", int'(m_item.count),
                                    int'(oldest_pending.count));
                if (m_item.status !== oldest_pending.status)
                    report_mismatch("status", int'(m_item.status),
                                    int'(oldest_pending.status));
                if (oldest_pending.status == STATUS_FULL) full_drops++;
                if (oldest_pending.status == STATUS_ABSENT) absent_deletes++;
            end
            results_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // edges of the key range, every op and the odd cases on a small set
    task automatic test_directed();
        send_item(OP_LOOKUP, '0);
        send_item(OP_DELETE, KEY_MAX);
        send_item(OP_INSERT, KEY_MAX);
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, 31'h2AAAAAAA);
        send_item(OP_INSERT, 31'h55555555);
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, 31'h55555555);
        send_item(OP_LOOKUP, KEY_MAX);
        send_item(OP_LOOKUP, 31'h40000000);
        send_item(OP_LOOKUP, 31'h7FFFFFFE);
        send_item(OP_UNUSED, 31'h55555555);
        send_item(OP_UNUSED, 31'h00000001);
        send_item(OP_DELETE, 31'h2AAAAAAA);
        send_item(OP_DELETE, 31'h2AAAAAAA);
        send_item(OP_DELETE, KEY_MAX);
        send_item(OP_DELETE, '0);
        send_item(OP_LOOKUP, 31'h55555555);
        send_item(OP_DELETE, 31'h55555555);
        send_item(OP_LOOKUP, KEY_MAX);
    endtask

    // fill to capacity, push against the full table, then empty it again
    task automatic test_fill_and_drain();
        logic [OpWidth-1:0] op;
        while (set_count < DEPTH) send_item(OP_INSERT, choose_key(8));
        repeat (8) begin
            op = ($urandom_range(0, 3) == 0) ? OP_LOOKUP : OP_INSERT;
            send_item(op, choose_key(30));
        end
        send_item(OP_INSERT, KEY_MAX);
        send_item(OP_INSERT, '0);
        while (set_count > 0) send_item(OP_DELETE, choose_key(85));
    endtask

    // random mix weighted toward inserts so the set keeps some depth
    task automatic test_random_ops(input int n);
        int sel;
        logic [OpWidth-1:0] op;
        repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) op = OP_INSERT;
            else if (sel < 70) op = OP_DELETE;
            else if (sel < 92) op = OP_LOOKUP;
            else op = OP_UNUSED;
            send_item(op, choose_key(50));
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        test_random_ops(25);
        test_fill_and_drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        run_phase(0, 0);
        run_phase(87, 0);
        run_phase(0, 87);
        run_phase(27, 27);
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d items and checked %0d results in %0d cycles",
                 items_sent, results_checked, cycle_count);
        $display("table filled and drained 4 times, %0d full drops, %0d absent deletes",
                 full_drops, absent_deletes);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
